>>> rtl/core/tssc_pkg.sv
// tssc_pkg: format kinds and the format classification table
// shared by the decode stage and the row geometry stage
// no dependencies
package tssc_pkg;

  localparam logic [2:0] KIND_PLAIN  = 3'd0;
  localparam logic [2:0] KIND_BLOCK  = 3'd1;
  localparam logic [2:0] KIND_PACKED = 3'd2;
  localparam logic [2:0] KIND_NV11   = 3'd3;
  localparam logic [2:0] KIND_PLANAR = 3'd4;

  localparam int ROW_BYTES_W   = 19;
  localparam int ROW_COUNT_W   = 16;
  localparam int TOTAL_BYTES_W = 33;

  localparam logic [ROW_BYTES_W-1:0]   ROW_BYTES_MAX   = '1;
  localparam logic [ROW_COUNT_W-1:0]   ROW_COUNT_MAX   = '1;
  localparam logic [TOTAL_BYTES_W-1:0] TOTAL_BYTES_MAX = '1;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] size;
  } fmt_t;

  // size is bits per pixel for plain formats, bytes per block, pair or group otherwise
  function automatic fmt_t classify(input logic [7:0] code);
    fmt_t f;
    f.kind = KIND_PLAIN;
    f.size = 8'd0;
    case (code) inside
      [8'd1:8'd4]:    f.size = 8'd128;
      [8'd5:8'd8]:    f.size = 8'd96;
      [8'd9:8'd22]:   f.size = 8'd64;
      [8'd23:8'd47]:  f.size = 8'd32;
      [8'd48:8'd59]:  f.size = 8'd16;
      [8'd60:8'd65]:  f.size = 8'd8;
      [8'd87:8'd93]:  f.size = 8'd32;
      8'd66:          f.size = 8'd1;
      8'd67:          f.size = 8'd32;
      8'd68, 8'd69, 8'd107: begin
        f.kind = KIND_PACKED;
        f.size = 8'd4;
      end
      8'd108, 8'd109: begin
        f.kind = KIND_PACKED;
        f.size = 8'd8;
      end
      8'd70, 8'd71, 8'd72, 8'd79, 8'd80, 8'd81: begin
        f.kind = KIND_BLOCK;
        f.size = 8'd8;
      end
      [8'd73:8'd78], [8'd82:8'd84], [8'd94:8'd99]: begin
        f.kind = KIND_BLOCK;
        f.size = 8'd16;
      end
      8'd85, 8'd86, 8'd114, 8'd115: f.size = 8'd16;
      8'd100, 8'd101: f.size = 8'd32;
      8'd102:         f.size = 8'd64;
      8'd103, 8'd106: begin
        f.kind = KIND_PLANAR;
        f.size = 8'd2;
      end
      8'd104, 8'd105: begin
        f.kind = KIND_PLANAR;
        f.size = 8'd4;
      end
      8'd110: begin
        f.kind = KIND_NV11;
        f.size = 8'd12;
      end
      8'd111, 8'd112, 8'd113: f.size = 8'd8;
      default: f.size = 8'd0;
    endcase
    return f;
  endfunction

endpackage

>>> rtl/core/tssc_decode.sv
// tssc_decode: first pipeline stage, clamps dimensions and classifies the format
// depends on tssc_pkg
module tssc_decode
  import tssc_pkg::*;
#(
  parameter int DIM_MAX = 16384,
  parameter int DW      = 15
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          up_valid,
  output logic          up_stall,
  input  logic [14:0]   width,
  input  logic [14:0]   height,
  input  logic [7:0]    format_code,
  output logic          dn_valid,
  input  logic          dn_stall,
  output logic [DW-1:0] w,
  output logic [DW-1:0] h,
  output fmt_t          fmt
);

  logic          valid;
  logic [DW-1:0] w_next;
  logic [DW-1:0] h_next;

  assign up_stall = valid && dn_stall;
  assign dn_valid = valid;

  always_comb begin
    w_next = (17'(width) > 17'(DIM_MAX)) ? DW'(DIM_MAX) : DW'(width);
    h_next = (17'(height) > 17'(DIM_MAX)) ? DW'(DIM_MAX) : DW'(height);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!up_stall) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!up_stall && up_valid) begin
      w   <= w_next;
      h   <= h_next;
      fmt <= classify(format_code);
    end
  end

endmodule

>>> rtl/core/tssc_rows.sv
// tssc_rows: second pipeline stage, row pitch, row count and plane multiplier
// depends on tssc_pkg
module tssc_rows
  import tssc_pkg::*;
#(
  parameter int DW = 15
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           up_valid,
  output logic           up_stall,
  input  logic [DW-1:0]  w,
  input  logic [DW-1:0]  h,
  input  fmt_t           fmt,
  output logic           dn_valid,
  input  logic           dn_stall,
  output logic [DW+4:0]  rb,
  output logic [DW:0]    mul_rows,
  output logic [DW:0]    rows,
  output logic           planar
);

  localparam int RBW = DW + 5;
  localparam int PLW = DW + 8;

  logic           valid;
  logic [DW:0]    w_pair;
  logic [DW:0]    w_quad;
  logic [DW:0]    h_quad;
  logic [DW:0]    h_half;
  logic [DW:0]    operand;
  logic [7:0]     factor;
  logic [PLW-1:0] prod;
  logic [RBW-1:0] rb_next;
  logic [DW:0]    mul_next;
  logic [DW:0]    rows_next;

  assign up_stall = valid && dn_stall;
  assign dn_valid = valid;

  always_comb begin
    w_pair  = ((DW+1)'(w) + (DW+1)'(1)) >> 1;
    w_quad  = ((DW+1)'(w) + (DW+1)'(3)) >> 2;
    h_quad  = ((DW+1)'(h) + (DW+1)'(3)) >> 2;
    h_half  = ((DW+1)'(h) + (DW+1)'(1)) >> 1;
    operand = (DW+1)'(w);
    factor  = fmt.size;
    case (fmt.kind)
      KIND_BLOCK:  operand = w_quad;
      KIND_NV11: begin
        operand = w_quad;
        factor  = 8'd4;
      end
      KIND_PACKED, KIND_PLANAR: operand = w_pair;
      default:     operand = (DW+1)'(w);
    endcase
    prod = PLW'(operand) * PLW'(factor);
    if (fmt.kind == KIND_PLAIN) begin
      rb_next = RBW'((prod + PLW'(7)) >> 3);
    end else begin
      rb_next = RBW'(prod);
    end
    case (fmt.kind)
      KIND_BLOCK: begin
        mul_next  = h_quad;
        rows_next = h_quad;
      end
      KIND_NV11: begin
        mul_next  = (DW+1)'(h) << 1;
        rows_next = (DW+1)'(h) << 1;
      end
      KIND_PLANAR: begin
        mul_next  = (DW+1)'(h);
        rows_next = (DW+1)'(h) + h_half;
      end
      default: begin
        mul_next  = (DW+1)'(h);
        rows_next = (DW+1)'(h);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!up_stall) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!up_stall && up_valid) begin
      rb       <= rb_next;
      mul_rows <= mul_next;
      rows     <= rows_next;
      planar   <= (fmt.kind == KIND_PLANAR);
    end
  end

endmodule

>>> rtl/core/tssc_total.sv
// tssc_total: third and fourth pipeline stages, plane product, planar
// extension and output saturation; depends on tssc_pkg
module tssc_total
  import tssc_pkg::*;
#(
  parameter int DW = 15
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     up_valid,
  output logic                     up_stall,
  input  logic [DW+4:0]            rb,
  input  logic [DW:0]              mul_rows,
  input  logic [DW:0]              rows,
  input  logic                     planar,
  output logic                     dn_valid,
  input  logic                     dn_stall,
  output logic [ROW_BYTES_W-1:0]   row_bytes,
  output logic [ROW_COUNT_W-1:0]   row_count,
  output logic [TOTAL_BYTES_W-1:0] total_bytes
);

  localparam int RBW = DW + 5;
  localparam int RW  = DW + 1;
  localparam int PW  = RBW + RW;
  localparam int TW  = PW + 1;
  localparam int RBX = (RBW > ROW_BYTES_W) ? RBW : ROW_BYTES_W;
  localparam int RWX = (RW > ROW_COUNT_W) ? RW : ROW_COUNT_W;
  localparam int TWX = (TW > TOTAL_BYTES_W) ? TW : TOTAL_BYTES_W;

  // stage 3
  logic                   valid3;
  logic                   stall3;
  logic [PW-1:0]          plane;
  logic                   planar3;
  logic [ROW_BYTES_W-1:0] rb3;
  logic [ROW_COUNT_W-1:0] rows3;
  logic [ROW_BYTES_W-1:0] rb_sat;
  logic [ROW_COUNT_W-1:0] rows_sat;
  logic [RBX-1:0]         rb_ext;
  logic [RWX-1:0]         rows_ext;

  // stage 4
  logic                   valid4;
  logic [TW-1:0]          total_raw;
  logic [TWX-1:0]         total_ext;

  assign dn_valid = valid4;
  assign stall3   = valid4 && dn_stall;
  assign up_stall = valid3 && stall3;

  always_comb begin
    rb_ext   = RBX'(rb);
    rows_ext = RWX'(rows);
    rb_sat   = (rb_ext > RBX'(ROW_BYTES_MAX)) ? ROW_BYTES_MAX : ROW_BYTES_W'(rb_ext);
    rows_sat = (rows_ext > RWX'(ROW_COUNT_MAX)) ? ROW_COUNT_MAX : ROW_COUNT_W'(rows_ext);
  end

  always_comb begin
    if (planar3) begin
      total_raw = TW'(plane) + ((TW'(plane) + TW'(1)) >> 1);
    end else begin
      total_raw = TW'(plane);
    end
    total_ext = TWX'(total_raw);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid3 <= 1'b0;
      valid4 <= 1'b0;
    end else begin
      if (!up_stall) begin
        valid3 <= up_valid;
      end
      if (!stall3) begin
        valid4 <= valid3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!up_stall && up_valid) begin
      plane   <= PW'(rb) * PW'(mul_rows);
      planar3 <= planar;
      rb3     <= rb_sat;
      rows3   <= rows_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall3 && valid3) begin
      total_bytes <= (total_ext > TWX'(TOTAL_BYTES_MAX)) ? TOTAL_BYTES_MAX
                                                       : TOTAL_BYTES_W'(total_ext);
      row_bytes   <= rb3;
      row_count   <= rows3;
    end
  end

  zero_rows_zero_total: assert property (@(posedge clk) disable iff (rst)
    valid4 && row_count == '0 |-> total_bytes == '0)
    else $error("zero rows with nonzero total");

  zero_pitch_zero_total: assert property (@(posedge clk) disable iff (rst)
    valid4 && row_bytes == '0 |-> total_bytes == '0)
    else $error("zero pitch with nonzero total");

  total_covers_row: assert property (@(posedge clk) disable iff (rst)
    valid4 && row_count != '0 |-> total_bytes >= TOTAL_BYTES_W'(row_bytes))
    else $error("total smaller than one row");

endmodule

>>> rtl/core/texture_surface_size_calc.sv
// texture_surface_size_calc: row pitch, row count and total size of a texture surface
// one transaction per cycle sustained while size_stall stays low
// stages: decode, row geometry, plane multiply, planar extension and saturation
// reset clears all stage valid bits; payload registers are not reset
// depends on tssc_pkg, tssc_decode, tssc_rows, tssc_total
module texture_surface_size_calc
  import tssc_pkg::*;
#(
  parameter int DIM_LIMIT = 16384
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     desc_valid,
  output logic                     desc_stall,
  input  logic [14:0]              width,
  input  logic [14:0]              height,
  input  logic [7:0]               format_code,
  output logic                     size_valid,
  input  logic                     size_stall,
  output logic [ROW_BYTES_W-1:0]   row_bytes,
  output logic [ROW_COUNT_W-1:0]   row_count,
  output logic [TOTAL_BYTES_W-1:0] total_bytes
);

  localparam int DIM_MAX = (DIM_LIMIT < 32767) ? DIM_LIMIT : 32767;
  localparam int DW_RAW  = $clog2(DIM_MAX + 1);
  localparam int DW      = (DW_RAW < 2) ? 2 : DW_RAW;

  logic          s1_valid;
  logic          s1_stall;
  logic [DW-1:0] s1_w;
  logic [DW-1:0] s1_h;
  fmt_t          s1_fmt;

  logic          s2_valid;
  logic          s2_stall;
  logic [DW+4:0] s2_rb;
  logic [DW:0]   s2_mul;
  logic [DW:0]   s2_rows;
  logic          s2_planar;

  tssc_decode #(
    .DIM_MAX (DIM_MAX),
    .DW      (DW)
  ) u_decode (
    .clk         (clk),
    .rst         (rst),
    .up_valid    (desc_valid),
    .up_stall    (desc_stall),
    .width       (width),
    .height      (height),
    .format_code (format_code),
    .dn_valid    (s1_valid),
    .dn_stall    (s1_stall),
    .w           (s1_w),
    .h           (s1_h),
    .fmt         (s1_fmt)
  );

  tssc_rows #(
    .DW (DW)
  ) u_rows (
    .clk      (clk),
    .rst      (rst),
    .up_valid (s1_valid),
    .up_stall (s1_stall),
    .w        (s1_w),
    .h        (s1_h),
    .fmt      (s1_fmt),
    .dn_valid (s2_valid),
    .dn_stall (s2_stall),
    .rb       (s2_rb),
    .mul_rows (s2_mul),
    .rows     (s2_rows),
    .planar   (s2_planar)
  );

  tssc_total #(
    .DW (DW)
  ) u_total (
    .clk         (clk),
    .rst         (rst),
    .up_valid    (s2_valid),
    .up_stall    (s2_stall),
    .rb          (s2_rb),
    .mul_rows    (s2_mul),
    .rows        (s2_rows),
    .planar      (s2_planar),
    .dn_valid    (size_valid),
    .dn_stall    (size_stall),
    .row_bytes   (row_bytes),
    .row_count   (row_count),
    .total_bytes (total_bytes)
  );

endmodule

>>> sim/tb.sv
// tb: self-checking bench for texture_surface_size_calc, random and directed surface descriptors
// predicts pitch, row count and size per transaction and compares against the result channel
// depends on tssc_pkg and the texture_surface_size_calc rtl
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tssc_pkg::*;

  localparam int          DIM_LIMIT   = 16384;
  localparam int          RAND_ITEMS  = 2000;
  localparam int          DRAIN_TICKS = 16;
  localparam longint      RUN_LIMIT   = 5_000_000;

  typedef struct {
    logic [14:0] width;
    logic [14:0] height;
    logic [7:0]  format_code;
  } surface_desc_t;

  typedef struct {
    logic [ROW_BYTES_W-1:0]   row_bytes;
    logic [ROW_COUNT_W-1:0]   row_count;
    logic [TOTAL_BYTES_W-1:0] total_bytes;
  } surface_size_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                     desc_valid  = 1'b0;
  logic                     desc_stall;
  logic [14:0]              width       = '0;
  logic [14:0]              height      = '0;
  logic [7:0]               format_code = '0;
  logic                     size_valid;
  logic                     size_stall  = 1'b0;
  logic [ROW_BYTES_W-1:0]   row_bytes;
  logic [ROW_COUNT_W-1:0]   row_count;
  logic [TOTAL_BYTES_W-1:0] total_bytes;

  surface_desc_t desc_backlog[$];
  surface_size_t size_expected[$];
  surface_desc_t desc_next;
  surface_size_t size_seen;

  int          desc_total = 0;
  int          desc_count = 0;
  int          errors     = 0;
  logic        desc_taken = 1'b0;
  int          burst_left = 1;
  int          gap_left   = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_left = 0;
  int          stall_phase = 0;

  texture_surface_size_calc #(
    .DIM_LIMIT(DIM_LIMIT)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .desc_valid(desc_valid),
    .desc_stall(desc_stall),
    .width(width),
    .height(height),
    .format_code(format_code),
    .size_valid(size_valid),
    .size_stall(size_stall),
    .row_bytes(row_bytes),
    .row_count(row_count),
    .total_bytes(total_bytes)
  );

  // format kind and size figure: bits per pixel for plain, bytes per block/pair/group otherwise
  function automatic void decode_format(input logic [7:0] code, output logic [2:0] kind,
                                        output longint unsigned sz);
    kind = KIND_PLAIN;
    sz   = 0;
    case (code)
      70, 71, 72, 79, 80, 81: begin
        kind = KIND_BLOCK;
        sz   = 8;
      end
      73, 74, 75, 76, 77, 78, 82, 83, 84, 94, 95, 96, 97, 98, 99: begin
        kind = KIND_BLOCK;
        sz   = 16;
      end
      68, 69, 107: begin
        kind = KIND_PACKED;
        sz   = 4;
      end
      108, 109: begin
        kind = KIND_PACKED;
        sz   = 8;
      end
      110: begin
        kind = KIND_NV11;
        sz   = 12;
      end
      103, 106: begin
        kind = KIND_PLANAR;
        sz   = 2;
      end
      104, 105: begin
        kind = KIND_PLANAR;
        sz   = 4;
      end
      66:                 sz = 1;
      67, 100, 101:       sz = 32;
      85, 86, 114, 115:   sz = 16;
      102:                sz = 64;
      111, 112, 113:      sz = 8;
      default: begin
        if (code >= 1 && code <= 4) sz = 128;
        else if (code >= 5 && code <= 8) sz = 96;
        else if (code >= 9 && code <= 22) sz = 64;
        else if (code >= 23 && code <= 47) sz = 32;
        else if (code >= 48 && code <= 59) sz = 16;
        else if (code >= 60 && code <= 65) sz = 8;
        else if (code >= 87 && code <= 93) sz = 32;
      end
    endcase
  endfunction

  function automatic surface_size_t surface_geometry(surface_desc_t d);
    longint unsigned w, h, sz, rb, rows, tot, plane;
    logic [2:0]      kind;
    surface_size_t   r;
    w = d.width;
    h = d.height;
    if (w > DIM_LIMIT) w = DIM_LIMIT;
    if (h > DIM_LIMIT) h = DIM_LIMIT;
    decode_format(d.format_code, kind, sz);
    case (kind)
      KIND_BLOCK: begin
        rb   = ((w == 0) ? 0 : (w + 3) / 4) * sz;
        rows = (h == 0) ? 0 : (h + 3) / 4;
        tot  = rb * rows;
      end
      KIND_PACKED: begin
        rb   = ((w + 1) >> 1) * sz;
        rows = h;
        tot  = rb * h;
      end
      KIND_NV11: begin
        rb   = ((w + 3) >> 2) * 4;
        rows = h * 2;
        tot  = rb * rows;
      end
      KIND_PLANAR: begin
        rb    = ((w + 1) >> 1) * sz;
        plane = rb * h;
        tot   = plane + ((plane + 1) >> 1);
        rows  = h + ((h + 1) >> 1);
      end
      default: begin
        rb   = (w * sz + 7) / 8;
        rows = h;
        tot  = rb * h;
      end
    endcase
    r.row_bytes   = (rb > ROW_BYTES_MAX) ? ROW_BYTES_MAX : rb[ROW_BYTES_W-1:0];
    r.row_count   = (rows > ROW_COUNT_MAX) ? ROW_COUNT_MAX : rows[ROW_COUNT_W-1:0];
    r.total_bytes = (tot > TOTAL_BYTES_MAX) ? TOTAL_BYTES_MAX : tot[TOTAL_BYTES_W-1:0];
    return r;
  endfunction

  function automatic logic [14:0] random_dim();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 15'($urandom_range(0, 40));
      4, 5:       return 15'($urandom_range(0, 32767));
      6:          return 15'($urandom_range(16380, 16388));
      7: begin
        case ($urandom_range(0, 2))
          0:       return 15'd0;
          1:       return 15'd16384;
          default: return 15'd32767;
        endcase
      end
      default:    return 15'($urandom_range(0, 16384));
    endcase
  endfunction

  task automatic queue_desc(input int w, input int h, input int code);
    surface_desc_t d;
    d.width       = 15'(w);
    d.height      = 15'(h);
    d.format_code = 8'(code);
    desc_backlog.push_back(d);
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // sender: bursts of random length separated by random gaps
  always @(negedge clk) begin
    if (rst) begin
      desc_valid <= 1'b0;
    end else if (!desc_valid || desc_taken) begin
      if (gap_left != 0) begin
        gap_left   <= gap_left - 1;
        desc_valid <= 1'b0;
      end else if (desc_backlog.size() != 0) begin
        desc_next   = desc_backlog.pop_front();
        width       <= desc_next.width;
        height      <= desc_next.height;
        format_code <= desc_next.format_code;
        desc_valid  <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        desc_valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern switches between modes every so often
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(10, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    stall_phase <= stall_phase + 1;
    case (stall_mode)
      STALL_NONE:     size_stall <= 1'b0;
      STALL_LIGHT:    size_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY:    size_stall <= ($urandom_range(0, 9) < 7);
      default:        size_stall <= (stall_phase % 3 == 0);
    endcase
  end

  // input side: predict each accepted transaction
  always @(posedge clk) begin
    desc_taken <= !rst && desc_valid && !desc_stall;
    if (!rst && desc_valid && !desc_stall) begin
      desc_next.width       = width;
      desc_next.height      = height;
      desc_next.format_code = format_code;
      size_expected.push_back(surface_geometry(desc_next));
      desc_count <= desc_count + 1;
    end
  end

  // result side: compare against the oldest prediction
  always @(posedge clk) begin
    if (!rst && size_valid && !size_stall) begin
      if (size_expected.size() == 0) begin
        $error("unexpected result transaction row_bytes %0d row_count %0d total_bytes %0d",
               row_bytes, row_count, total_bytes);
        errors = errors + 1;
      end else begin
        size_seen = size_expected.pop_front();
        if (row_bytes !== size_seen.row_bytes) begin
          $error("row_bytes expected %0d actual %0d", size_seen.row_bytes, row_bytes);
          errors = errors + 1;
        end
        if (row_count !== size_seen.row_count) begin
          $error("row_count expected %0d actual %0d", size_seen.row_count, row_count);
          errors = errors + 1;
        end
        if (total_bytes !== size_seen.total_bytes) begin
          $error("total_bytes expected %0d actual %0d", size_seen.total_bytes, total_bytes);
          errors = errors + 1;
        end
      end
    end
  end

  initial begin
    // directed: dimension extremes, every format kind, unknown codes, zero-size blocks
    queue_desc(0, 0, 0);
    queue_desc(16384, 16384, 2);
    queue_desc(32767, 32767, 2);
    queue_desc(1, 1, 66);
    queue_desc(7, 3, 66);
    queue_desc(16384, 16384, 66);
    queue_desc(0, 5, 71);
    queue_desc(5, 0, 71);
    queue_desc(1, 1, 71);
    queue_desc(16384, 16384, 74);
    queue_desc(32767, 1, 98);
    queue_desc(3, 7, 68);
    queue_desc(16384, 16384, 108);
    queue_desc(1, 1, 107);
    queue_desc(5, 3, 110);
    queue_desc(16384, 16384, 110);
    queue_desc(3, 5, 103);
    queue_desc(16384, 16384, 104);
    queue_desc(1, 1, 106);
    queue_desc(100, 100, 0);
    queue_desc(100, 100, 116);
    queue_desc(100, 100, 255);
    queue_desc(32767, 32767, 255);
    queue_desc(9, 9, 85);
    queue_desc(17000, 32767, 6);
    for (int i = 0; i < RAND_ITEMS; i++) begin
      queue_desc(random_dim(), random_dim(),
                 ($urandom_range(0, 9) < 8) ? $urandom_range(0, 115) : $urandom_range(0, 255));
    end
    desc_total = desc_backlog.size();
    while (desc_count != desc_total || size_expected.size() != 0) @(negedge clk);
    repeat (DRAIN_TICKS) @(negedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #RUN_LIMIT;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
